// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// House form: the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_CLK_RST(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/core/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Branch target set package
// Sizes, operation codes and the structs shared by the set cells.
// ----------------------------------------------------------------------------
package bts_pkg;

	// Number of ways in the set and the width of a way number.
	localparam int WAYS  = 8;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef logic [WAY_W-1:0] way_idx_t;
	typedef logic [2:0]       op_t;

	// Operation codes.
	localparam op_t OP_PROBE     = 3'd0;
	localparam op_t OP_ACCESS    = 3'd1;
	localparam op_t OP_INSERT    = 3'd2;
	localparam op_t OP_INVAL     = 3'd3;
	localparam op_t OP_INVAL_ALL = 3'd4;

	// Broadcast to every way cell during the execute cycle.
	typedef struct packed {
		logic        exec;
		op_t         op;
		logic [63:0] pc;
		logic [63:0] data;
	} cell_ctrl_t;

	// Priority chain handed from way cell to way cell, lowest way first.
	typedef struct packed {
		logic        hit;
		way_idx_t    hit_way;
		logic [63:0] rdata;
		logic        free;
		way_idx_t    free_way;
	} way_chain_t;

	// Low three bits of a way number, zero-extended for small sets.
	function automatic logic [2:0] way_field(way_idx_t w);
		logic [WAY_W+2:0] ext;
		ext = {3'b000, w};
		return ext[2:0];
	endfunction

endpackage

// ===== rtl/core/bts_way_cell.sv =====
// ----------------------------------------------------------------------------
// Branch target way cell
// Holds one way (tag, valid, payload), compares it against the broadcast
// address and extends the hit and free-way priority chain.
// ----------------------------------------------------------------------------
module bts_way_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bts_pkg::way_idx_t   cell_index,
	input  bts_pkg::cell_ctrl_t ctrl,
	input  bts_pkg::way_idx_t   victim,
	input  bts_pkg::way_chain_t chain_in,
	output bts_pkg::way_chain_t chain_out
);
	import bts_pkg::*;

	logic        valid_q;
	logic [63:0] tag_q;
	logic [63:0] payload_q;
	logic        match;
	logic        first_hit;
	logic        first_free;
	logic        write_en;

	// Tag compare and the first-match / first-free selection.
	assign match      = valid_q && (tag_q == ctrl.pc);
	assign first_hit  = match && !chain_in.hit;
	assign first_free = !valid_q && !chain_in.free;
	assign write_en   = ctrl.exec && (ctrl.op == OP_INSERT) && (victim == cell_index);

	// Extend the chain toward the higher ways.
	always_comb begin
		chain_out.hit      = chain_in.hit | match;
		chain_out.hit_way  = chain_in.hit_way | (first_hit ? cell_index : '0);
		chain_out.rdata    = chain_in.rdata | (first_hit ? payload_q : 64'd0);
		chain_out.free     = chain_in.free | !valid_q;
		chain_out.free_way = chain_in.free_way | (first_free ? cell_index : '0);
	end

	// Valid bit: set by insert, cleared by a matching invalidate or by flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.exec) begin
			unique case (ctrl.op)
				OP_INSERT: begin
					if (write_en) valid_q <= 1'b1;
				end
				OP_INVAL: begin
					if (match) valid_q <= 1'b0;
				end
				OP_INVAL_ALL: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Tag and payload storage, written only by insert.
	always_ff @(posedge clk) begin
		if (write_en) begin
			tag_q     <= ctrl.pc;
			payload_q <= ctrl.data;
		end
	end

endmodule

// ===== rtl/core/bts_lru_cell.sv =====
// ----------------------------------------------------------------------------
// Recency slot cell
// One slot of the oldest-to-newest way list. On promotion, each slot from the
// promoted way up copies its upper neighbor; the top takes the promoted way.
// ----------------------------------------------------------------------------
module bts_lru_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bts_pkg::way_idx_t reset_way,
	input  logic              promote_en,
	input  bts_pkg::way_idx_t promote_way,
	input  logic              seen_in,
	input  bts_pkg::way_idx_t next_way,
	output logic              seen_out,
	output bts_pkg::way_idx_t slot_way
);
	import bts_pkg::*;

	way_idx_t slot_q;

	// Tell the upper slots whether the promoted way sits here or below.
	assign seen_out = seen_in | (slot_q == promote_way);
	assign slot_way = slot_q;

	// Shift down by one from the promoted way's position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= reset_way;
		end else if (promote_en && seen_out) begin
			slot_q <= next_way;
		end
	end

endmodule

// ===== rtl/core/branch_target_set_lru.sv =====
// ----------------------------------------------------------------------------
// Branch target set with LRU replacement
// The result is computed in the execute state and presented from the result register in the done state.
// One item at a time: a new item is accepted only after the result is handed off (capture, execute, hand-off).
// Reset clears every valid bit and sets the recency list to way 0 oldest.
// ----------------------------------------------------------------------------
module branch_target_set_lru (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  operation,
	input  logic [63:0] branch_pc,
	input  logic [63:0] entry_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic [2:0]  way,
	output logic [63:0] read_data
);
	import bts_pkg::*;
	`include "assert_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	op_t         op_q;
	logic [63:0] pc_q;
	logic [63:0] data_q;
	logic        hit_q;
	logic [2:0]  way_q;
	logic [63:0] rdata_q;

	cell_ctrl_t  ctrl;
	way_chain_t  chain [WAYS+1];
	way_idx_t    slot  [WAYS];
	logic        seen  [WAYS+1];
	way_idx_t    victim;
	logic        promote_en;
	way_idx_t    promote_way;
	logic        res_hit;
	logic [2:0]  res_way;
	logic [63:0] res_rdata;

	// Handshake: one item in flight at a time.
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_DONE);
	assign hit       = hit_q;
	assign way       = way_q;
	assign read_data = rdata_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_stall) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_q   <= operation;
			pc_q   <= branch_pc;
			data_q <= entry_data;
		end
	end

	// Broadcast to the way cells.
	always_comb begin
		ctrl.exec = (state_q == ST_EXEC);
		ctrl.op   = op_q;
		ctrl.pc   = pc_q;
		ctrl.data = data_q;
	end

	assign chain[0] = '0;
	assign seen[0]  = 1'b0;

	// Row of way cells, lowest way first.
	for (genvar i = 0; i < WAYS; i++) begin : g_way
		bts_way_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_index(way_idx_t'(i)),
			.ctrl      (ctrl),
			.victim    (victim),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// Row of recency slots, oldest first.
	for (genvar i = 0; i < WAYS; i++) begin : g_lru
		way_idx_t next_way;
		if (i == WAYS - 1) begin : g_top
			assign next_way = promote_way;
		end else begin : g_mid
			assign next_way = slot[i+1];
		end
		bts_lru_cell u_slot (
			.clk        (clk),
			.arst_n     (arst_n),
			.reset_way  (way_idx_t'(i)),
			.promote_en (promote_en),
			.promote_way(promote_way),
			.seen_in    (seen[i]),
			.next_way   (next_way),
			.seen_out   (seen[i+1]),
			.slot_way   (slot[i])
		);
	end

	// Replacement choice: lowest invalid way, else the oldest way.
	assign victim = chain[WAYS].free ? chain[WAYS].free_way : slot[0];

	// Result and recency update for the item in execute.
	always_comb begin
		promote_en  = 1'b0;
		promote_way = chain[WAYS].hit_way;
		res_hit     = 1'b0;
		res_way     = 3'd0;
		res_rdata   = 64'd0;
		unique case (op_q)
			OP_PROBE, OP_ACCESS: begin
				if (chain[WAYS].hit) begin
					res_hit    = 1'b1;
					res_way    = way_field(chain[WAYS].hit_way);
					res_rdata  = chain[WAYS].rdata;
					promote_en = ctrl.exec && (op_q == OP_ACCESS);
				end
			end
			OP_INSERT: begin
				res_hit     = 1'b1;
				res_way     = way_field(victim);
				promote_way = victim;
				promote_en  = ctrl.exec;
			end
			OP_INVAL: begin
				if (chain[WAYS].hit) begin
					res_hit = 1'b1;
					res_way = way_field(chain[WAYS].hit_way);
				end
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			hit_q   <= res_hit;
			way_q   <= res_way;
			rdata_q <= res_rdata;
		end
	end

	`ASSERT_STD(a_rsp_blocks_req, rsp_valid |-> req_stall, "request taken while result pending")
	`ASSERT_STD(a_insert_hit, (ctrl.exec && op_q == OP_INSERT) |=> hit_q, "insert without hit")
	`ASSERT_STD(a_promote_newest, (ctrl.exec && promote_en) |=> (slot[WAYS-1] == $past(promote_way)), "promoted way not newest")
	`ASSERT_STD(a_flush_empty, (ctrl.exec && op_q == OP_INVAL_ALL) |=> (chain[WAYS].free && chain[WAYS].free_way == '0), "ways valid after flush")

endmodule

// ===== sim/tb_branch_target_set_lru.sv =====
// ----------------------------------------------------------------------------
// Branch target set testbench
// Feeds probe, access, insert, invalidate, invalidate-all and spare-code items
// into the set with random gaps on the request side and random stalls on the
// result side. Each accepted item updates a local model of tags, valid bits,
// payloads and recency order, and the returned results are checked in order.
// ----------------------------------------------------------------------------
module tb_branch_target_set_lru;

	import bts_pkg::*;

	// Spare operation codes that must leave the set untouched.
	localparam op_t OP_SPARE_LO  = 3'd5;
	localparam op_t OP_SPARE_MID = 3'd6;
	localparam op_t OP_SPARE_HI  = 3'd7;

	localparam int RANDOM_ITEMS = 380;
	localparam int POOL_SIZE    = 12;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 10;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		op_t         op;
		logic [63:0] pc;
		logic [63:0] data;
	} set_item_t;

	typedef struct {
		logic        hit;
		logic [2:0]  way;
		logic [63:0] rdata;
	} set_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  operation = OP_PROBE;
	logic [63:0] branch_pc = '0;
	logic [63:0] entry_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        hit;
	logic [2:0]  way;
	logic [63:0] read_data;

	set_item_t   pending_items[$];
	set_result_t expected_results[$];
	int          total_items;
	int          accepted_items = 0;
	int          mismatches = 0;
	bit          req_fire = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// Local copy of the set.
	logic [63:0] shadow_tag[WAYS];
	logic        shadow_valid[WAYS];
	logic [63:0] shadow_payload[WAYS];
	int          shadow_order[WAYS];

	logic [63:0] pc_pool[POOL_SIZE];
	set_result_t want;

	branch_target_set_lru dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.branch_pc  (branch_pc),
		.entry_data (entry_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.hit        (hit),
		.way        (way),
		.read_data  (read_data)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// The first twenty items out of each hundred draw no random idling on either side.
	function automatic bit quiet_phase();
		return (accepted_items % 100) < 20;
	endfunction

	// Idle length: mostly zero or short, now and then long.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 25);
	endfunction

	// Lowest valid way holding this tag, or WAYS when none does.
	function automatic int find_match(logic [63:0] pc);
		for (int w = 0; w < WAYS; w++)
			if (shadow_valid[w] && shadow_tag[w] == pc)
				return w;
		return WAYS;
	endfunction

	// Move a way to the most recent end of the recency order.
	function automatic void promote_way(int w);
		int p;
		p = 0;
		while (p < WAYS && shadow_order[p] != w)
			p++;
		if (p == WAYS)
			return;
		for (int q = p; q + 1 < WAYS; q++)
			shadow_order[q] = shadow_order[q + 1];
		shadow_order[WAYS - 1] = w;
	endfunction

	function automatic void reset_shadow();
		for (int w = 0; w < WAYS; w++) begin
			shadow_tag[w] = '0;
			shadow_payload[w] = '0;
			shadow_valid[w] = 1'b0;
			shadow_order[w] = w;
		end
	endfunction

	// Apply one item to the local copy and return the result it produces.
	function automatic set_result_t predict_lookup(set_item_t it);
		set_result_t r;
		int w;
		r = '{1'b0, 3'd0, 64'd0};
		case (it.op)
			OP_PROBE, OP_ACCESS: begin
				w = find_match(it.pc);
				if (w < WAYS) begin
					r.hit = 1'b1;
					r.way = 3'(w);
					r.rdata = shadow_payload[w];
					if (it.op == OP_ACCESS)
						promote_way(w);
				end
			end
			OP_INSERT: begin
				w = 0;
				while (w < WAYS && shadow_valid[w])
					w++;
				if (w == WAYS)
					w = shadow_order[0];
				shadow_tag[w] = it.pc;
				shadow_payload[w] = it.data;
				shadow_valid[w] = 1'b1;
				promote_way(w);
				r.hit = 1'b1;
				r.way = 3'(w);
			end
			OP_INVAL: begin
				w = find_match(it.pc);
				if (w < WAYS) begin
					r.hit = 1'b1;
					r.way = 3'(w);
				end
				for (int v = 0; v < WAYS; v++)
					if (shadow_valid[v] && shadow_tag[v] == it.pc)
						shadow_valid[v] = 1'b0;
			end
			OP_INVAL_ALL: begin
				for (int v = 0; v < WAYS; v++)
					shadow_valid[v] = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void add_item(op_t op, logic [63:0] pc, logic [63:0] data);
		set_item_t it;
		it.op = op;
		it.pc = pc;
		it.data = data;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Random item drawn mostly from a small address pool so that hits are common.
	function automatic void add_random_item();
		int r;
		op_t op;
		logic [63:0] pc;
		logic [63:0] data;
		r = $urandom_range(0, 99);
		if (r < 20)
			op = OP_PROBE;
		else if (r < 45)
			op = OP_ACCESS;
		else if (r < 75)
			op = OP_INSERT;
		else if (r < 90)
			op = OP_INVAL;
		else if (r < 93)
			op = OP_INVAL_ALL;
		else
			op = op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if ($urandom_range(0, 99) < 5)
			pc_pool[$urandom_range(0, POOL_SIZE - 1)] = rand64();
		if ($urandom_range(0, 99) < 85)
			pc = pc_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			pc = rand64();
		r = $urandom_range(0, 19);
		if (r == 0)
			data = '0;
		else if (r == 1)
			data = '1;
		else
			data = rand64();
		add_item(op, pc, data);
	endfunction

	function automatic void report_mismatch(string field, logic [63:0] exp_v,
	                                        logic [63:0] got_v);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
	endfunction

	// Request side: offer the next item at the falling edge, hold it while stalled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_fire) begin
				// Stalled item stays on the bus unchanged.
			end else if (send_gap > 0 && hold_left == 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				set_item_t it;
				it = pending_items.pop_front();
				req_valid <= 1'b1;
				operation <= it.op;
				branch_pc <= it.pc;
				entry_data <= it.data;
				send_gap = quiet_phase() ? 0 : pick_idle();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: random stalls, and one long hold-off to back the set up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet_phase() && $urandom_range(0, 99) < 30) begin
				stall_left = pick_idle();
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Predict each accepted item and check each accepted result in order.
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire = req_valid && !req_stall;
			if (req_fire) begin
				set_item_t it;
				it.op = operation;
				it.pc = branch_pc;
				it.data = entry_data;
				expected_results.insert(expected_results.size(), predict_lookup(it));
				accepted_items++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", '0, {61'd0, way});
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", 64'(want.hit), 64'(hit));
					if (way !== want.way)
						report_mismatch("way", 64'(want.way), 64'(way));
					if (read_data !== want.rdata)
						report_mismatch("read_data", want.rdata, read_data);
				end
			end
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		reset_shadow();
		for (int i = 0; i < POOL_SIZE; i++)
			pc_pool[i] = rand64();
		pc_pool[0] = '0;
		pc_pool[1] = '1;

		// Misses on an empty set.
		add_item(OP_PROBE, 64'd0, 64'd0);
		add_item(OP_ACCESS, '1, '1);
		add_item(OP_INVAL, 64'd0, '1);
		// Fill all ways, the last one a duplicate tag of way 0.
		add_item(OP_INSERT, 64'd0, '1);
		add_item(OP_INSERT, '1, 64'd0);
		add_item(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		add_item(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		add_item(OP_INSERT, 64'd1, rand64());
		add_item(OP_INSERT, 64'd2, rand64());
		add_item(OP_INSERT, 64'h8000_0000_0000_0000, rand64());
		add_item(OP_INSERT, 64'd0, 64'h0123_4567_89AB_CDEF);
		// Hits: probe leaves order alone, access refreshes.
		add_item(OP_PROBE, 64'd0, 64'd0);
		add_item(OP_ACCESS, '1, 64'd0);
		add_item(OP_ACCESS, 64'd0, 64'd0);
		// Full set: insert replaces the oldest way.
		add_item(OP_INSERT, 64'd3, rand64());
		// Invalidate clears both copies of a duplicated tag.
		add_item(OP_INVAL, 64'd0, 64'd0);
		add_item(OP_PROBE, 64'd0, 64'd0);
		// Insert now fills the lowest free way.
		add_item(OP_INSERT, 64'd4, rand64());
		// Spare codes change nothing.
		add_item(OP_SPARE_LO, '1, '1);
		add_item(OP_SPARE_MID, 64'd1, '1);
		add_item(OP_SPARE_HI, '1, 64'd0);
		add_item(OP_INVAL_ALL, '1, '1);
		add_item(OP_PROBE, '1, 64'd0);
		add_item(OP_INSERT, '1, '1);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_random_item();
		total_items = pending_items.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_items < total_items)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
